>>> hdl/spwsm_pkg.sv
// Shared types and constants for the signed pulse-width speed meter.
// No dependencies; imported by every module of the block.
package spwsm_pkg;

    // Field and bus widths
    localparam int SCALE_W     = 16;
    localparam int SPEED_W     = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    // Register map
    localparam logic [REG_IDX_W-1:0] REG_SPEED_SCALE = '0;
    localparam logic [SCALE_W-1:0]   SCALE_RESET     = 16'hFFFF;

    // Input tdata bit positions
    localparam int IN_START_BIT = 0;
    localparam int IN_SIG_BIT   = 1;
    localparam int IN_DIR_BIT   = 2;

    // Restoring divider: one quotient bit per cycle
    localparam int QUO_STEPS = SCALE_W;
    localparam int STEP_W    = $clog2(QUO_STEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUO_STEPS - 1);

    // Speed saturation limit
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'h7FFF;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // start: latch reference, load budget, clear width
        logic budget_dec;   // one tick of a wait phase
        logic width_first;  // opposite level began: width becomes one
        logic width_inc;    // opposite level continues
        logic div_start;    // pulse ended: latch numerator, divisor, sign
        logic div_step;     // one divider iteration
        logic out_timeout;  // load output with a timeout result
        logic out_speed;    // load output with the divider result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic start;        // start flag of the current sample
        logic opp;          // sample is at the opposite level
        logic budget_low;   // budget is zero or one
        logic width_hit;    // incremented width reaches the budget
        logic width_zero;   // width is zero
    } t_dp_status;

endpackage

>>> hdl/signed_pulse_width_speed_meter.sv
// Signed pulse-width speed meter takes one sample per cycle while a measurement
// waits for or counts a pulse and the output register is free; a sample that ends a
// pulse starts a 16-step restoring divide (one quotient bit per cycle), and the
// input stalls from the divide until the speed result is loaded. Timeouts and start
// ticks do not stall the input. One output register separates the result
// stream; new samples are taken while it drains if the sink is ready.
// Top level: instantiates spwsm_regs, spwsm_ctrl and spwsm_dp; uses spwsm_pkg.
module signed_pulse_width_speed_meter #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Sample stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [spwsm_pkg::IN_TDATA_W-1:0]        s_tdata,   // start_req, sig_level, dir_level, pad
    // Result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [spwsm_pkg::OUT_TDATA_W-1:0]       m_tdata,   // speed
    output logic                                    m_tuser,   // timed_out
    // Configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [spwsm_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [spwsm_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [spwsm_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import spwsm_pkg::*;

    logic [SCALE_W-1:0] speed_scale;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    // Configuration registers
    spwsm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_speed_scale (speed_scale)
    );

    // Phase control and handshakes
    spwsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Counters, divider and result payload
    spwsm_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_start       (s_tdata[IN_START_BIT]),
        .i_sig         (s_tdata[IN_SIG_BIT]),
        .i_dir         (s_tdata[IN_DIR_BIT]),
        .i_speed_scale (speed_scale),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .o_speed       (m_tdata),
        .o_timed_out   (m_tuser)
    );

endmodule

>>> hdl/spwsm_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on spwsm_pkg.
module spwsm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spwsm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spwsm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spwsm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output logic [spwsm_pkg::SCALE_W-1:0]       o_speed_scale
);
    import spwsm_pkg::*;

    logic [SCALE_W-1:0]   r_speed_scale;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_scale <= SCALE_RESET;
        end else if (wr_en && (reg_idx == REG_SPEED_SCALE)) begin
            r_speed_scale <= pwdata[SCALE_W-1:0];
        end
    end

    // Read mux
    always_comb begin
        if (reg_idx == REG_SPEED_SCALE) begin
            prdata = {(APB_DATA_W - SCALE_W)'(0), r_speed_scale};
        end else begin
            prdata = '0;
        end
    end

    assign o_speed_scale = r_speed_scale;

endmodule

>>> hdl/spwsm_dp.sv
// Datapath: reference level, tick budget, pulse width, restoring divider
// and the output payload register. Depends on spwsm_pkg.
module spwsm_dp #(
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_start,
    input  logic                            i_sig,
    input  logic                            i_dir,
    input  logic [spwsm_pkg::SCALE_W-1:0]   i_speed_scale,
    input  spwsm_pkg::t_dp_cmd              i_cmd,
    output spwsm_pkg::t_dp_status           o_status,
    output logic [spwsm_pkg::SPEED_W-1:0]   o_speed,
    output logic                            o_timed_out
);
    import spwsm_pkg::*;

    localparam int WIDE_W = (COUNT_BITS > SCALE_W) ? COUNT_BITS : SCALE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_ref;
    logic [COUNT_BITS-1:0] r_budget;
    logic [COUNT_BITS-1:0] r_width;
    logic [COUNT_BITS-1:0] r_dvsr;
    logic [COUNT_BITS-1:0] r_rem;
    logic [SCALE_W-1:0]    r_quo;
    logic                  r_neg;
    logic [SPEED_W-1:0]    r_speed;
    logic                  r_timed_out;

    logic [WIDE_W-1:0]     scale_wide;
    logic [COUNT_BITS-1:0] budget_load;
    logic [COUNT_BITS:0]   width_next;
    logic [COUNT_BITS:0]   rem_shift;
    logic [COUNT_BITS:0]   rem_diff;
    logic                  quo_bit;
    logic [SPEED_W-1:0]    speed_mag;

    // Budget load value, saturated to the counter range
    assign scale_wide  = WIDE_W'(i_speed_scale);
    assign budget_load = (scale_wide > WIDE_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : COUNT_BITS'(scale_wide);

    // Status toward the controller
    assign width_next          = {1'b0, r_width} + (COUNT_BITS+1)'(1);
    assign o_status.start      = i_start;
    assign o_status.opp        = (i_sig != r_ref);
    assign o_status.budget_low = (r_budget <= COUNT_BITS'(1));
    assign o_status.width_hit  = (width_next >= {1'b0, r_budget});
    assign o_status.width_zero = (r_width == '0);

    // One restoring divide step
    assign rem_shift = {r_rem, r_quo[SCALE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_dvsr};
    assign quo_bit   = (rem_shift >= {1'b0, r_dvsr});

    // Saturate the quotient magnitude; the sign is applied in the output payload
    assign speed_mag = r_quo[SCALE_W-1] ? SPEED_MAX : r_quo;

    // Measurement counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref    <= i_sig;
            r_budget <= budget_load;
            r_width  <= '0;
        end else begin
            if (i_cmd.budget_dec) begin
                r_budget <= r_budget - COUNT_BITS'(1);
            end
            if (i_cmd.width_first) begin
                r_width <= COUNT_BITS'(1);
            end else if (i_cmd.width_inc) begin
                r_width <= width_next[COUNT_BITS-1:0];
            end
        end
    end

    // Divider: divisor is width + 1, numerator is the current scale
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvsr <= width_next[COUNT_BITS-1:0];
            r_rem  <= '0;
            r_quo  <= i_speed_scale;
            r_neg  <= i_dir ^ r_ref;
        end else if (i_cmd.div_step) begin
            r_rem <= quo_bit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
            r_quo <= {r_quo[SCALE_W-2:0], quo_bit};
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_timeout) begin
            r_speed     <= '0;
            r_timed_out <= 1'b1;
        end else if (i_cmd.out_speed) begin
            r_speed     <= r_neg ? (SPEED_W'(0) - speed_mag) : speed_mag;
            r_timed_out <= 1'b0;
        end
    end

    assign o_speed     = r_speed;
    assign o_timed_out = r_timed_out;

endmodule

>>> hdl/spwsm_ctrl.sv
// Controller: measurement phases, divider sequencing and stream handshakes.
// Depends on spwsm_pkg.
module spwsm_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    input  spwsm_pkg::t_dp_status   i_status,
    output spwsm_pkg::t_dp_cmd      o_cmd
);
    import spwsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_END,
        ST_WAIT_BEGIN,
        ST_COUNT,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    logic                out_free;
    logic                accept;
    t_dp_cmd             cmd;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state != ST_DIVIDE) && (r_state != ST_FINISH) && out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    // Next state and datapath commands
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_step  = r_step;
        if (accept && i_status.start) begin
            cmd.load = 1'b1;
            n_state  = ST_WAIT_END;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                end
                ST_WAIT_END, ST_WAIT_BEGIN: begin
                    if (accept) begin
                        if ((r_state == ST_WAIT_BEGIN) && i_status.opp) begin
                            // opposite level began: first counted tick
                            cmd.width_first = 1'b1;
                            if (i_status.budget_low) begin
                                cmd.out_timeout = 1'b1;
                                n_state         = ST_IDLE;
                            end else begin
                                n_state = ST_COUNT;
                            end
                        end else if (i_status.budget_low) begin
                            cmd.out_timeout = 1'b1;
                            n_state         = ST_IDLE;
                        end else begin
                            cmd.budget_dec = 1'b1;
                            n_state = (r_state == ST_WAIT_END && i_status.opp) ? ST_WAIT_END
                                                                                : ST_WAIT_BEGIN;
                        end
                    end
                end
                ST_COUNT: begin
                    if (accept) begin
                        if (i_status.opp) begin
                            cmd.width_inc = 1'b1;
                            if (i_status.width_hit) begin
                                cmd.out_timeout = 1'b1;
                                n_state         = ST_IDLE;
                            end
                        end else if (i_status.width_zero) begin
                            cmd.out_timeout = 1'b1;
                            n_state         = ST_IDLE;
                        end else begin
                            cmd.div_start = 1'b1;
                            n_step        = '0;
                            n_state       = ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    cmd.div_step = 1'b1;
                    n_step       = r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        n_state = ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        cmd.out_speed = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end

        // Output register valid
        if (cmd.out_timeout || cmd.out_speed) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd      = cmd;
    assign o_m_tvalid = r_out_valid;

endmodule
